@@ hdl/rdx_pkg.sv @@
// Shared constants, types and the digit character mapping of the radix converter.
package rdx_pkg;

  localparam int VALUE_W    = 32;
  localparam int MAX_DIGITS = 32;
  localparam int DIG_W      = 6;
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(VALUE_W - 1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_LIMIT = 1'b1;

  localparam logic [CFG_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [CFG_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [CFG_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(MAX_DIGITS);
  localparam logic [CFG_W-1:0] LIMIT_MAX   = CFG_W'(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_ZERO
  } rdx_state_e;

  // Result of one division step sequence.
  typedef struct packed {
    logic               done;
    logic               q_nz;
    logic [DIG_W-1:0]   rem;
    logic [VALUE_W-1:0] quot;
  } rdx_div_res_t;

  // Maps a remainder to its ASCII digit, '0'-'9' then 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {1'b0, d};
    end else if (d < 6'd36) begin
      c = CHAR_A + {1'b0, d - 6'd10};
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

@@ hdl/rdx_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock cycle.
module rdx_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rdx_pkg::VALUE_W-1:0] dividend_i,
  input  logic [rdx_pkg::DIG_W-1:0]   divisor_i,
  output rdx_pkg::rdx_div_res_t       res_o
);
  import rdx_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  cnt_q;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [DIG_W-1:0]   rem_q, rem_d;
  logic [DIG_W-1:0]   div_q;
  logic               nz_q;
  logic [DIG_W:0]     shifted;
  logic               fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem_q, quo_q[VALUE_W-1]};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? DIG_W'(shifted - {1'b0, div_q}) : shifted[DIG_W-1:0];
    quo_d   = {quo_q[VALUE_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
      nz_q  <= 1'b0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      nz_q  <= nz_q | fits;
    end
  end

  assign res_o.done = done_q;
  assign res_o.q_nz = nz_q;
  assign res_o.rem  = rem_q;
  assign res_o.quot = quo_q;

endmodule

@@ hdl/radix_integer_to_digits.sv @@
// Top level of the radix converter: control, digit store and output register.
//
// Each accepted 32-bit value is converted to ASCII digits in the base held in
// the radix register (2 to 36, out-of-range settings saturate), using '0'-'9'
// then 'A'-'Z'. The digits leave most significant first, one beat each, with
// tlast on the final one. A zero value gives a single beat with tdata zero and
// tuser bit 0 (empty) set. When the value needs more digits than the digit
// limit allows, only the lowest-order digits are sent and tuser bit 1
// (truncated) is set on every beat of that value. Each digit is produced by a
// bit-serial divider and is then read back from the digit store into the
// output register. A new value is taken only once the previous one has been
// fully handed to the output register. A configuration write takes effect at
// once, so the registers must only be written while the block is idle.
module radix_integer_to_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [rdx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rdx_pkg::CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // [31:0] value
  // Output stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // [6:0] digit_char, [7] zero pad
  output logic                          m_axis_tlast_o,
  output logic [1:0]                    m_axis_tuser_o   // [0] empty_res, [1] truncated
);
  import rdx_pkg::*;

  rdx_state_e          state_q, state_d;
  logic [CFG_W-1:0]    radix_q;
  logic [CFG_W-1:0]    limit_q;
  logic [DIG_W-1:0]    base_sat;
  logic [CNT_W-1:0]    limit_sat;
  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    n_inc;
  logic [IDX_W-1:0]    idx_q;
  logic                cut_q;
  logic [DIG_W-1:0]    mem [MAX_DIGITS];
  logic [DIG_W-1:0]    rd_data_q;

  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q;
  logic                out_empty_q;
  logic                out_trunc_q;
  logic                out_free;

  logic                in_acc;
  logic                in_zero;
  logic                more;

  logic                div_start;
  logic [VALUE_W-1:0]  div_dividend;
  rdx_div_res_t        div_res;

  logic                mem_we;
  logic                mem_re;
  logic                load_digit;
  logic                load_zero;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIX:       radix_q <= cfg_data_i;
        REG_DIGIT_LIMIT: limit_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Out-of-range settings saturate to the nearest meaningful value.
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      base_sat = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base_sat = RADIX_MAX;
    end else begin
      base_sat = radix_q;
    end
    if (limit_q == '0) begin
      limit_sat = CNT_W'(1);
    end else if (limit_q > LIMIT_MAX) begin
      limit_sat = CNT_W'(LIMIT_MAX);
    end else begin
      limit_sat = CNT_W'(limit_q);
    end
  end

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_zero  = s_axis_tdata_i == '0;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign n_inc    = n_q + 1'b1;
  // Another digit is needed while quotient remains and the limit allows it.
  assign more     = div_res.q_nz && (n_inc < limit_sat);

  rdx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (base_sat),
    .res_o      (div_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_zero ? ST_ZERO : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = more ? ST_DIV : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) begin
          state_d = (idx_q == '0) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    div_dividend    = div_res.quot;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    load_digit      = 1'b0;
    load_zero       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        div_start       = in_acc && !in_zero;
        div_dividend    = s_axis_tdata_i;
      end
      ST_DIV: begin
        mem_we    = div_res.done;
        div_start = div_res.done && more;
      end
      ST_EMIT_RD: mem_re     = 1'b1;
      ST_EMIT_WR: load_digit = out_free;
      ST_ZERO:    load_zero  = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      idx_q   <= '0;
      cut_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        n_q <= '0;
      end else if (mem_we) begin
        n_q <= n_inc;
      end
      // The top digit sits at the index just written.
      if (mem_we && !more) begin
        idx_q <= n_q[IDX_W-1:0];
        cut_q <= div_res.q_nz;
      end else if (load_digit) begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  // Digit store, least significant digit at index zero.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[n_q[IDX_W-1:0]] <= div_res.rem;
    end
    if (mem_re) begin
      rd_data_q <= mem[idx_q];
    end
  end

  // Output register; the sequencer loads it only when it is free or its beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_digit || load_zero) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_digit) begin
      out_char_q  <= digit_char(rd_data_q);
      out_last_q  <= idx_q == '0;
      out_empty_q <= 1'b0;
      out_trunc_q <= cut_q;
    end else if (load_zero) begin
      out_char_q  <= '0;
      out_last_q  <= 1'b1;
      out_empty_q <= 1'b1;
      out_trunc_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_trunc_q, out_empty_q};

  // An empty beat always closes its value and is never marked truncated.
  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_last_q && !out_trunc_q)
    else $error("empty beat without last or with truncated");

  // The divider only finishes while the sequencer is waiting for it.
  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");

  // Reads only touch digits written for the current value.
  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> CNT_W'(idx_q) < n_q)
    else $error("digit read beyond the digits produced");

  // The digit count never passes the limit.
  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> n_q < limit_sat)
    else $error("digit count reached the limit while dividing");

endmodule

@@ dv/radix_integer_to_digits_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the radix integer-to-digits converter.
module radix_integer_to_digits_tb;

  // Digit alphabet of the converter: the remainder indexes this string directly.
  localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // One expected output beat, field by field.
  typedef struct packed {
    logic [6:0] digit_char;
    logic       last;
    logic       empty_res;
    logic       truncated;
  } digit_beat_t;

  logic clk;
  logic rst_n;

  logic                          cfg_we;
  logic [rdx_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [rdx_pkg::CFG_W-1:0]     cfg_data;

  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value

  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [6:0] digit_char, [7] zero pad
  logic        m_tlast;
  logic [1:0]  m_tuser;   // [0] empty_res, [1] truncated

  // The testbench's own copy of the two format registers, as last written.
  logic [rdx_pkg::CFG_W-1:0] radix_set;
  logic [rdx_pkg::CFG_W-1:0] limit_set;

  // Digit beats predicted but not yet seen on the output, oldest first.
  digit_beat_t digits_due[$];
  int unsigned mismatch_count;

  // Random idling on both sides is switched off for the pressure test and the
  // quiet tail of the run.
  bit          stall_en;
  // Length of a long output hold-off; the sink process counts it down.
  int unsigned hold_cycles;

  radix_integer_to_digits dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hung block must not hang the run: the slowest legal run stays below
  // a millisecond, so this only fires when beats have gone missing.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Base actually used: settings below two or above thirty-six saturate.
  function automatic int unsigned effective_radix();
    int unsigned base;
    base = radix_set;
    if (base < 2) begin
      base = 2;
    end else if (base > 36) begin
      base = 36;
    end
    return base;
  endfunction

  // Works out the digit beats of one accepted value and queues them. The
  // remainders come out least significant first and are sent in reverse; once
  // the digit limit is reached with a quotient still left, the high-order
  // digits are dropped and every kept beat carries the truncated flag.
  function automatic void predict_digits(input logic [31:0] value);
    int unsigned base;
    int unsigned cap;
    int unsigned count;
    int unsigned quot;
    logic [5:0]  rems[rdx_pkg::MAX_DIGITS];
    digit_beat_t beat;
    base = effective_radix();
    cap  = limit_set;
    if (cap == 0) begin
      cap = 1;
    end else if (cap > rdx_pkg::MAX_DIGITS) begin
      cap = rdx_pkg::MAX_DIGITS;
    end
    // A zero value has no digits at all: a single empty beat stands for it.
    if (value == 0) begin
      beat = '{digit_char: 7'd0, last: 1'b1, empty_res: 1'b1, truncated: 1'b0};
      digits_due.push_back(beat);
      return;
    end
    quot  = value;
    count = 0;
    while (quot != 0 && count < cap) begin
      rems[count] = 6'(quot % base);
      quot        = quot / base;
      count++;
    end
    for (int k = count; k > 0; k--) begin
      beat.digit_char = 7'(DIGIT_SET[rems[k-1]]);
      beat.last       = (k == 1);
      beat.empty_res  = 1'b0;
      beat.truncated  = (quot != 0);
      digits_due.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready driver and checker
  // ---------------------------------------------------------------------------

  // Drives tready at the falling edge. A long hold-off requested by a test
  // takes precedence; otherwise tready drops in short random stall bursts.
  initial begin : sink_ready_driver
    int unsigned burst;
    burst    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else if (burst != 0) begin
        m_tready = 1'b0;
        burst--;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        burst    = $urandom_range(1, 16) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Every accepted output beat is compared with the oldest expectation.
  always @(posedge clk) begin : digit_checker
    digit_beat_t due;
    if (rst_n && m_tvalid && m_tready) begin
      if (digits_due.size() == 0) begin
        $error("digit beat with nothing expected: tdata %0h, tlast %0b, tuser %0b",
               m_tdata, m_tlast, m_tuser);
        mismatch_count++;
      end else begin
        due = digits_due.pop_front();
        if (m_tdata[6:0] !== due.digit_char) begin
          $error("digit_char: expected %0h, actual %0h", due.digit_char, m_tdata[6:0]);
          mismatch_count++;
        end
        if (m_tlast !== due.last) begin
          $error("last: expected %0b, actual %0b", due.last, m_tlast);
          mismatch_count++;
        end
        if (m_tuser[0] !== due.empty_res) begin
          $error("empty_res: expected %0b, actual %0b", due.empty_res, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tuser[1] !== due.truncated) begin
          $error("truncated: expected %0b, actual %0b", due.truncated, m_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration
  // ---------------------------------------------------------------------------

  // Offers one value, sometimes after a random gap, and predicts its digits
  // at the rising edge at which it is accepted. tvalid stays high on return so
  // that back-to-back values are offered without a bubble.
  task automatic send_value(input logic [31:0] value);
    @(negedge clk);
    if (stall_en && $urandom_range(0, 2) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = value;
    do @(posedge clk); while (!s_tready);
    predict_digits(value);
  endtask

  // Stops offering and waits until every predicted beat has arrived, then waits
  // longer so that the block is back in its idle state.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rdx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rdx_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == rdx_pkg::REG_RADIX) begin
      radix_set = data;
    end else begin
      limit_set = data;
    end
  endtask

  // Changes the number format between phases, only once the block is idle.
  task automatic set_format(input logic [rdx_pkg::CFG_W-1:0] radix,
                            input logic [rdx_pkg::CFG_W-1:0] limit);
    wait_idle();
    write_reg(rdx_pkg::REG_RADIX, radix);
    write_reg(rdx_pkg::REG_DIGIT_LIMIT, limit);
  endtask

  // Random value shaped to reach every digit count: full-width values,
  // values of random magnitude, zero, and the edges around powers of the base.
  function automatic logic [31:0] pick_value(input int unsigned base);
    int unsigned power;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2, 3: return $urandom();
      4, 5, 6: return $urandom() >> $urandom_range(1, 31);
      default: begin
        power = 1;
        repeat ($urandom_range(1, 31)) begin
          if (power <= 32'hFFFF_FFFF / base) power *= base;
        end
        return power - $urandom_range(0, 1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Decimal with the full digit limit straight out of reset.
  task automatic test_reset_format();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567890);
    send_value(32'h8000_0000);
  endtask

  // Smallest and largest bases, and settings outside 2 to 36 that saturate.
  task automatic test_radix_extremes();
    set_format(6'd2, 6'd32);
    send_value(32'hFFFF_FFFF);   // 32 binary digits, exactly at the limit
    send_value(32'd1);
    set_format(6'd36, 6'd32);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hFFFF_FFFF);
    set_format(6'd16, 6'd32);
    send_value(32'hDEAD_BEEF);
    set_format(6'd0, 6'd32);
    send_value(32'd5);
    set_format(6'd1, 6'd32);
    send_value(32'd6);
    set_format(6'd37, 6'd32);
    send_value(32'd71);
    set_format(6'd63, 6'd32);
    send_value(32'd1295);
  endtask

  // Digit limit: a cut leaves the low-order digits and flags every beat;
  // zero behaves as one and anything above the store depth saturates.
  task automatic test_digit_limit();
    set_format(6'd10, 6'd1);
    send_value(32'd12345);
    send_value(32'd7);
    set_format(6'd10, 6'd0);
    send_value(32'd98);
    set_format(6'd10, 6'd3);
    send_value(32'd999);
    send_value(32'd1000);
    set_format(6'd2, 6'd33);
    send_value(32'hA5A5_A5A5);
    set_format(6'd2, 6'd63);
    send_value(32'h5A5A_5A5A);
  endtask

  // The sink holds off for a long stretch while values keep coming, so the
  // block fills its output register and must stall its input.
  task automatic test_output_backpressure();
    set_format(6'd36, 6'd32);
    stall_en = 1'b0;
    @(posedge clk);
    hold_cycles = 400;
    repeat (8) send_value($urandom_range(1, 1295));
    wait_idle();
    stall_en = 1'b1;
  endtask

  // Phases of random values, each under a freshly chosen format.
  task automatic test_random_formats();
    logic [rdx_pkg::CFG_W-1:0] radix;
    logic [rdx_pkg::CFG_W-1:0] limit;
    for (int phase = 0; phase < 10; phase++) begin
      radix = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(2, 36));
      case ($urandom_range(0, 3))
        0:       limit = 6'($urandom_range(0, 63));
        1:       limit = 6'($urandom_range(1, 8));
        default: limit = 6'd32;
      endcase
      set_format(radix, limit);
      repeat (21) send_value(pick_value(effective_radix()));
    end
    wait_idle();
  endtask

  // The closing stretch runs at full rate with no idling on either side.
  task automatic test_quiet_tail();
    set_format(6'($urandom_range(2, 36)), 6'd32);
    stall_en = 1'b0;
    repeat (20) send_value(pick_value(effective_radix()));
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = rdx_pkg::REG_RADIX;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    radix_set      = rdx_pkg::RADIX_RESET;
    limit_set      = rdx_pkg::LIMIT_RESET;
    stall_en       = 1'b1;
    hold_cycles    = 0;
    mismatch_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_format();
    test_radix_extremes();
    test_digit_limit();
    test_output_backpressure();
    test_random_formats();
    test_quiet_tail();

    // Leave room for any stray beat after the last expected one.
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
